// ----- hdl/nsr_pkg.sv -----
// Shared types and constants for the Newton square root block.
// Holds the controller/datapath command and status structs and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

    // Guesses, remainder and quotient are carried at full 64-bit precision
    localparam int GUESS_W = 64;
    localparam int ROOT_W  = 24;
    localparam int TOL_W   = 32;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Index of the tolerance register within the register map
    localparam logic REG_TOLERANCE = 1'b0;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd1;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic take_avg;
        logic next_guess;
        logic load_out;
        logic out_special;
        logic out_limit;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic div_last;
        logic converged;
        logic iter_last;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/nsr_ctrl.sv -----
// Sequencer for the Newton square root block.
// Drives the datapath by commands and owns the input and output handshakes.
// Depends on nsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire nsr_pkg::status_t status,
    output nsr_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_AVG    = 3'd3;
    localparam logic [2:0] ST_CMP    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       spec_reg, spec_next;
    logic       lim_reg, lim_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        spec_next       = spec_reg;
        lim_next        = lim_reg;
        cmd             = '0;
        cmd.out_special = spec_reg;
        cmd.out_limit   = lim_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.special)
                begin
                    spec_next  = 1'b1;
                    lim_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    spec_next     = 1'b0;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                cmd.take_avg = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.converged)
                begin
                    lim_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (status.iter_last)
                begin
                    lim_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // advance to the next guess and restart the divider at once
                    cmd.next_guess = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            spec_reg      <= 1'b0;
            lim_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            spec_reg      <= spec_next;
            lim_reg       <= lim_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nsr_datapath.sv -----
// Datapath of the Newton square root block: operand and guess registers,
// a restoring fixed-point divider (one quotient bit a cycle), averaging,
// convergence compare and the output register. Depends on nsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsr_datapath #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int MAX_ITERS  = 32
) (
    input  wire logic                      clk,
    input  wire logic [DATA_WIDTH-1:0]     value,
    input  wire logic [nsr_pkg::TOL_W-1:0] tolerance,
    input  wire nsr_pkg::cmd_t             cmd,
    output nsr_pkg::status_t               status,
    output logic [nsr_pkg::ROOT_W-1:0]     root,
    output logic                           is_nan,
    output logic                           hit_limit
);

    localparam int GW        = nsr_pkg::GUESS_W;
    localparam int TOTAL     = DATA_WIDTH + FRAC_BITS;
    localparam int BIT_CNT_W = $clog2(TOTAL + 1);
    localparam int ITER_W    = $clog2(MAX_ITERS);

    logic [DATA_WIDTH-1:0] v_reg;
    logic [DATA_WIDTH-1:0] numsh_reg, numsh_next;
    logic [GW-1:0]         last_reg, last_next;
    logic [GW-1:0]         next_reg, next_next;
    logic [GW-1:0]         rem_reg, rem_next;
    logic [GW-1:0]         quo_reg, quo_next;
    logic                  sat_reg, sat_next;
    logic [BIT_CNT_W-1:0]  bitcnt_reg, bitcnt_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [nsr_pkg::ROOT_W-1:0] root_reg, root_next;
    logic                  nan_reg, nan_next;
    logic                  lim_reg, lim_next;

    logic [GW-1:0] v_wide;
    logic          v_neg;
    logic [GW-1:0] rem_sh;
    logic          take;
    logic [GW-1:0] quotient;
    logic [GW-1:0] avg_sum;
    logic [GW-1:0] diff;

    assign v_wide = GW'(v_reg);
    assign v_neg  = v_reg[DATA_WIDTH-1];

    // One restoring step; the bit shifted out of the remainder forces a subtract
    assign rem_sh = {rem_reg[GW-2:0], numsh_reg[DATA_WIDTH-1]};
    assign take   = rem_reg[GW-1] || (rem_sh >= last_reg);

    // Saturated or zero-divisor quotient reads as all ones
    assign quotient = (sat_reg || (last_reg == '0)) ? '1 : quo_reg;
    assign avg_sum  = (last_reg >> 1) + (quotient >> 1)
                      + GW'(last_reg[0] & quotient[0]);

    assign diff = (last_reg > next_reg) ? (last_reg - next_reg) : (next_reg - last_reg);

    assign status.special   = v_neg || (v_wide == '0) || (v_wide == (GW'(1) << FRAC_BITS));
    assign status.div_last  = (bitcnt_reg == BIT_CNT_W'(1));
    assign status.converged = (diff <= GW'(tolerance));
    assign status.iter_last = (iter_reg == ITER_W'(MAX_ITERS - 1));

    always_comb
    begin
        numsh_next  = numsh_reg;
        last_next   = last_reg;
        next_next   = next_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        sat_next    = sat_reg;
        bitcnt_next = bitcnt_reg;
        iter_next   = iter_reg;
        root_next   = root_reg;
        nan_next    = nan_reg;
        lim_next    = lim_reg;

        if (cmd.load_in)
        begin
            last_next = GW'(value);
            iter_next = '0;
        end
        if (cmd.next_guess)
        begin
            last_next = next_reg;
            iter_next = iter_reg + ITER_W'(1);
        end
        if (cmd.div_start)
        begin
            numsh_next  = v_reg;
            rem_next    = '0;
            quo_next    = '0;
            sat_next    = 1'b0;
            bitcnt_next = BIT_CNT_W'(TOTAL);
        end
        if (cmd.div_step)
        begin
            // operand bits enter MSB first, then zeros for the fraction shift
            numsh_next  = {numsh_reg[DATA_WIDTH-2:0], 1'b0};
            rem_next    = take ? (rem_sh - last_reg) : rem_sh;
            sat_next    = sat_reg | quo_reg[GW-1];
            quo_next    = {quo_reg[GW-2:0], take};
            bitcnt_next = bitcnt_reg - BIT_CNT_W'(1);
        end
        if (cmd.take_avg)
        begin
            next_next = avg_sum;
        end
        if (cmd.load_out)
        begin
            if (cmd.out_special)
            begin
                root_next = v_neg ? '0 : v_wide[nsr_pkg::ROOT_W-1:0];
                nan_next  = v_neg;
                lim_next  = 1'b0;
            end
            else
            begin
                root_next = next_reg[nsr_pkg::ROOT_W-1:0];
                nan_next  = 1'b0;
                lim_next  = cmd.out_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg <= value;
        end
        numsh_reg  <= numsh_next;
        last_reg   <= last_next;
        next_reg   <= next_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sat_reg    <= sat_next;
        bitcnt_reg <= bitcnt_next;
        iter_reg   <= iter_next;
        root_reg   <= root_next;
        nan_reg    <= nan_next;
        lim_reg    <= lim_next;
    end

    assign root      = root_reg;
    assign is_nan    = nan_reg;
    assign hit_limit = lim_reg;

endmodule

`default_nettype wire

// ----- hdl/newton_square_root.sv -----
// Newton square root, top level: register port, controller and datapath.
// Depends on nsr_pkg, nsr_ctrl and nsr_datapath.
//
// Usage
//   Input channel (in_valid / in_stall / value): one signed fixed-point operand
//   per transfer. in_stall is low only while the block is idle, so one
//   operand is in flight at a time.
//   Output channel (out_valid / out_stall / root / is_nan / hit_limit): one
//   result per operand, held in an output register. A new operand is taken
//   while a finished result still waits there.
//   Negative, zero and exactly-one operands skip the divider and go from the
//   check to the output register. Otherwise each Newton step runs the
//   one-bit-per-cycle divider over DATA_WIDTH + FRAC_BITS quotient bits,
//   then an average and a compare; at most MAX_ITERS steps run, and the
//   result is loaded into the output register after the last step.
//   The next operand is taken only once that result has been loaded.
//   If the receiver stalls, the result holds in the output register and a
//   following result waits in the datapath until that register empties.
//   Reset clears the handshakes and sets tolerance to 1; the APB port
//   holds tolerance at address 0, is always ready and reads back its value.
`timescale 1ns / 1ps
`default_nettype none

module newton_square_root #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int MAX_ITERS  = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nsr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [nsr_pkg::APB_W-1:0]   pwdata,
    output logic      [nsr_pkg::APB_W-1:0]   prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [nsr_pkg::ROOT_W-1:0]  root,
    output logic                             is_nan,
    output logic                             hit_limit
);

    logic [nsr_pkg::TOL_W-1:0] tol_reg, tol_next;
    logic                      reg_sel;
    nsr_pkg::cmd_t             cmd;
    nsr_pkg::status_t          status;

    // Register index is the word address above the byte offset
    assign reg_sel = (paddr[nsr_pkg::ADDR_W-1] == nsr_pkg::REG_TOLERANCE);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? tol_reg : '0;

    always_comb
    begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            tol_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= nsr_pkg::TOL_RESET;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    nsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nsr_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_ITERS  (MAX_ITERS)
    ) u_datapath (
        .clk       (clk),
        .value     (value),
        .tolerance (tol_reg),
        .cmd       (cmd),
        .status    (status),
        .root      (root),
        .is_nan    (is_nan),
        .hit_limit (hit_limit)
    );

endmodule

`default_nettype wire

// ----- sim/nsr_checker.sv -----
// Checker for the Newton square root block: predicts each root from the operand
// and the tolerance register, then compares results in order of transfer.
// Depends on nsr_pkg for widths and the register index.
`timescale 1ns / 1ps

module nsr_checker #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32,
    parameter int MAX_ITERS  = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [nsr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [nsr_pkg::APB_W-1:0]   pwdata,
    input  wire logic                        pready,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [DATA_WIDTH-1:0]       value,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [nsr_pkg::ROOT_W-1:0]  root,
    input  wire logic                        is_nan,
    input  wire logic                        hit_limit,
    output int                               fail_count,
    output int                               pending,
    output int                               checked_count,
    output int                               nan_count,
    output int                               limit_count
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [nsr_pkg::ROOT_W-1:0] root;
        logic                       is_nan;
        logic                       hit_limit;
    } sqrt_result_t;

    sqrt_result_t                expected_roots[$];
    logic [nsr_pkg::TOL_W-1:0]   tolerance;

    // floor((num << FRAC_BITS) / den), all ones when the quotient overflows or den is zero
    function automatic logic [nsr_pkg::GUESS_W-1:0] scaled_quotient(
        input logic [nsr_pkg::GUESS_W-1:0] num,
        input logic [nsr_pkg::GUESS_W-1:0] den
    );
        logic [2*nsr_pkg::GUESS_W-1:0] wide;
        if (den == '0)
            return '1;
        wide = ((2*nsr_pkg::GUESS_W)'(num) << FRAC_BITS) / (2*nsr_pkg::GUESS_W)'(den);
        if (wide[2*nsr_pkg::GUESS_W-1:nsr_pkg::GUESS_W] != '0)
            return '1;
        return wide[nsr_pkg::GUESS_W-1:0];
    endfunction

    function automatic sqrt_result_t predict_root(
        input logic [DATA_WIDTH-1:0]     operand,
        input logic [nsr_pkg::TOL_W-1:0] tol
    );
        sqrt_result_t                res;
        logic [nsr_pkg::GUESS_W-1:0] opnd;
        logic [nsr_pkg::GUESS_W-1:0] guess;
        logic [nsr_pkg::GUESS_W-1:0] next_guess;
        logic [nsr_pkg::GUESS_W-1:0] quo;
        logic [nsr_pkg::GUESS_W-1:0] diff;
        logic                        settled;
        int                          step;
        res  = '0;
        opnd = nsr_pkg::GUESS_W'(operand);
        if (operand[DATA_WIDTH-1])
        begin
            res.is_nan = 1'b1;
            return res;
        end
        if (opnd == '0 || opnd == (nsr_pkg::GUESS_W'(1) << FRAC_BITS))
        begin
            res.root = opnd[nsr_pkg::ROOT_W-1:0];
            return res;
        end
        guess      = opnd;
        next_guess = '0;
        settled    = 1'b0;
        for (step = 0; step < MAX_ITERS && !settled; step++)
        begin
            quo        = scaled_quotient(opnd, guess);
            // floor of the mean without a carry out of the top bit
            next_guess = (guess >> 1) + (quo >> 1)
                         + nsr_pkg::GUESS_W'(guess[0] & quo[0]);
            diff       = (guess > next_guess) ? guess - next_guess : next_guess - guess;
            if (diff <= nsr_pkg::GUESS_W'(tol))
                settled = 1'b1;
            else
                guess = next_guess;
        end
        res.root      = next_guess[nsr_pkg::ROOT_W-1:0];
        res.hit_limit = !settled;
        return res;
    endfunction

    task automatic note_mismatch(input sqrt_result_t want, input sqrt_result_t got);
        if (fail_count < MAX_REPORTS)
            $display("%0t: root mismatch: expected root=%h nan=%b limit=%b,",
                     $time, want.root, want.is_nan, want.hit_limit,
                     " got root=%h nan=%b limit=%b",
                     got.root, got.is_nan, got.hit_limit);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sqrt_result_t got;
        sqrt_result_t want;
        if (!rst_n)
        begin
            tolerance = nsr_pkg::TOL_RESET;
            expected_roots.delete();
            pending       = 0;
            fail_count    = 0;
            checked_count = 0;
            nan_count     = 0;
            limit_count   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr[nsr_pkg::ADDR_W-1:2] == nsr_pkg::REG_TOLERANCE)
                tolerance = pwdata[nsr_pkg::TOL_W-1:0];

            if (out_valid && !out_stall)
            begin
                got.root      = root;
                got.is_nan    = is_nan;
                got.hit_limit = hit_limit;
                if (expected_roots.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: result transfer with nothing outstanding:",
                                 $time, " root=%h nan=%b limit=%b",
                                 got.root, got.is_nan, got.hit_limit);
                    fail_count++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (got.root !== want.root || got.is_nan !== want.is_nan ||
                        got.hit_limit !== want.hit_limit)
                        note_mismatch(want, got);
                    checked_count++;
                    if (want.is_nan)
                        nan_count++;
                    if (want.hit_limit)
                        limit_count++;
                end
            end

            if (in_valid && !in_stall)
                expected_roots.push_back(predict_root(value, tolerance));

            pending = expected_roots.size();
        end
    end

endmodule

// ----- sim/tb_newton_square_root.sv -----
// Testbench top for the Newton square root block: clock, reset, APB writes of the
// tolerance and operand/result traffic with random idling; nsr_checker does the checking.
// Depends on nsr_pkg, newton_square_root and nsr_checker.
`timescale 1ns / 1ps

module tb_newton_square_root;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int MAX_ITERS  = 32;

    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 83;
    localparam int LONG_HOLD_CYCLES = 4000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int STEP_CYCLES      = DATA_WIDTH + FRAC_BITS + 2;
    // worst case: every operand capped, plus sender gaps and receiver stalls, taken four times
    localparam longint CYCLE_LIMIT  = 4 * 850 * (MAX_ITERS * STEP_CYCLES + 400) + LONG_HOLD_CYCLES;

    localparam logic [nsr_pkg::ADDR_W-1:0] TOL_ADDR =
        nsr_pkg::ADDR_W'(nsr_pkg::REG_TOLERANCE) << 2;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [nsr_pkg::ADDR_W-1:0]    paddr;
    logic [nsr_pkg::APB_W-1:0]     pwdata;
    logic [nsr_pkg::APB_W-1:0]     prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic [DATA_WIDTH-1:0]         value;
    logic                          out_valid;
    logic                          out_stall;
    logic [nsr_pkg::ROOT_W-1:0]    root;
    logic                          is_nan;
    logic                          hit_limit;

    int fail_count;
    int pending;
    int checked_count;
    int nan_count;
    int limit_count;

    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_cycles;
    int     sent_count;
    int     tol_writes;
    longint cycle_count;

    // zero, one, both signs at their extremes, tiny and near-one operands, exact squares
    logic [DATA_WIDTH-1:0] directed_ops [20] = '{
        32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0001, 32'h0000_0002, 32'h0000_FFFF, 32'h0001_0001, 32'h0002_0000,
        32'h0004_0000, 32'h0009_0000, 32'h0100_0000, 32'h4000_0000, 32'h7FFF_0000,
        32'h5555_5555, 32'h2AAA_AAAA, 32'h0000_8000, 32'hFFFF_0000, 32'h00FF_FFFF
    };

    newton_square_root #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_ITERS  (MAX_ITERS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root),
        .is_nan    (is_nan),
        .hit_limit (hit_limit)
    );

    nsr_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_ITERS  (MAX_ITERS)
    ) root_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .root          (root),
        .is_nan        (is_nan),
        .hit_limit     (hit_limit),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .nan_count     (nan_count),
        .limit_count   (limit_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding",
                         cycle_count, pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default:
            begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase
    endtask

    task automatic write_tolerance(input logic [nsr_pkg::TOL_W-1:0] tol);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOL_ADDR;
        pwdata  <= nsr_pkg::APB_W'(tol);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tol_writes++;
    endtask

    task automatic send_operand(input logic [DATA_WIDTH-1:0] operand);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= operand;
        // hold the operand until the transfer
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // Drop valid and wait for every outstanding root
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [nsr_pkg::TOL_W-1:0] pick_tolerance(input int phase);
        case (phase % 5)
            0:       return nsr_pkg::TOL_W'(1);
            1:       return '0;
            2:       return '1;
            3:       return nsr_pkg::TOL_W'($urandom_range(64, 2));
            default: return nsr_pkg::TOL_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_operand();
        int unsigned      pick;
        logic [31:0]      k;
        pick = $urandom_range(99);
        k    = $urandom_range(46340, 0);
        if (pick < 12)
            return 32'h8000_0000 | $urandom;
        else if (pick < 40)
            return $urandom & 32'h7FFF_FFFF;
        else if (pick < 65)
            return ($urandom & 32'h7FFF_FFFF) >> $urandom_range(31, 1);
        else if (pick < 80)
            return k * k;
        else if (pick < 88)
            case ($urandom_range(3))
                0:       return 32'h0000_0000;
                1:       return 32'h0001_0000;
                2:       return 32'h0000_0001;
                default: return 32'h7FFF_FFFF;
            endcase
        else
            return 32'h0000_FF00 + $urandom_range(512);
    endfunction

    initial
    begin : stimulus
        int phase;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        value       = '0;
        hold_cycles = 0;
        sent_count  = 0;
        tol_writes  = 0;
        set_idle(IDLE_NONE);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed operands run at the reset tolerance
        foreach (directed_ops[i])
            send_operand(directed_ops[i]);
        drain_results();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_tolerance(pick_tolerance(phase));
            set_idle(idle_mode_t'(phase % 4));
            // fill the block behind a long receiver hold-off
            if (phase == 2)
                hold_cycles = LONG_HOLD_CYCLES;
            repeat (ITEMS_PER_PHASE)
                send_operand(random_operand());
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d operands under %0d tolerance writes; checked %0d roots",
                 sent_count, tol_writes, checked_count);
        $display("including %0d negative operands and %0d capped at the iteration limit",
                 nan_count, limit_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
